>>> design/eulr_pkg.sv
// ----------------------------------------------------------------------------
// eulr_pkg
// Shared types and constants for the Euler-angle rotation matrix block.
// ----------------------------------------------------------------------------
`default_nettype none
package eulr_pkg;
	localparam int CORDIC_STAGES = 16;
	localparam logic signed [33:0] ANG_PI      = 34'sd3373259426;
	localparam logic signed [33:0] ANG_HALF_PI = 34'sd1686629713;
	localparam logic signed [33:0] GAIN_Q30    = 34'sd652032874;
	localparam logic signed [15:0] SAT_MAX     = 16'sd16384;

	typedef logic signed [33:0] q30_t;
	typedef logic signed [21:0] q20_t;

	typedef struct packed {
		logic signed [15:0] angle_x;
		logic signed [15:0] angle_y;
		logic signed [15:0] angle_z;
	} angles_t;

	typedef struct packed {
		logic signed [15:0] m00;
		logic signed [15:0] m01;
		logic signed [15:0] m02;
		logic signed [15:0] m10;
		logic signed [15:0] m11;
		logic signed [15:0] m12;
		logic signed [15:0] m20;
		logic signed [15:0] m21;
		logic signed [15:0] m22;
	} matrix_t;

	// Arctangent of 2^-i in Q30, truncated; index wraps modulo 32.
	function automatic q30_t atan_tab(input logic [4:0] k);
		case (k)
			5'd0:  atan_tab = 34'sd843314856;
			5'd1:  atan_tab = 34'sd497837829;
			5'd2:  atan_tab = 34'sd263043836;
			5'd3:  atan_tab = 34'sd133525158;
			5'd4:  atan_tab = 34'sd67021686;
			5'd5:  atan_tab = 34'sd33543515;
			5'd6:  atan_tab = 34'sd16775850;
			5'd7:  atan_tab = 34'sd8388437;
			5'd8:  atan_tab = 34'sd4194282;
			5'd9:  atan_tab = 34'sd2097149;
			5'd10: atan_tab = 34'sd1048575;
			5'd11: atan_tab = 34'sd524287;
			5'd12: atan_tab = 34'sd262143;
			5'd13: atan_tab = 34'sd131071;
			5'd14: atan_tab = 34'sd65535;
			5'd15: atan_tab = 34'sd32767;
			5'd16: atan_tab = 34'sd16383;
			5'd17: atan_tab = 34'sd8191;
			5'd18: atan_tab = 34'sd4095;
			5'd19: atan_tab = 34'sd2047;
			5'd20: atan_tab = 34'sd1023;
			5'd21: atan_tab = 34'sd511;
			5'd22: atan_tab = 34'sd255;
			5'd23: atan_tab = 34'sd127;
			5'd24: atan_tab = 34'sd63;
			5'd25: atan_tab = 34'sd31;
			5'd26: atan_tab = 34'sd15;
			5'd27: atan_tab = 34'sd7;
			5'd28: atan_tab = 34'sd3;
			5'd29: atan_tab = 34'sd1;
			default: atan_tab = 34'sd0;
		endcase
	endfunction
endpackage
`default_nettype wire

>>> design/eulr_stream_if.sv
// ----------------------------------------------------------------------------
// eulr_stream_if
// Valid/ready channels for angle requests and matrix results.
// ----------------------------------------------------------------------------
`default_nettype none
interface eulr_angle_if;
	logic             valid;
	logic             ready;
	eulr_pkg::angles_t data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface eulr_matrix_if;
	logic              valid;
	logic              ready;
	eulr_pkg::matrix_t data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> design/eulr_cordic.sv
// ----------------------------------------------------------------------------
// eulr_cordic
// Pipelined CORDIC: one rotation per stage, giving Q20 sine and cosine.
// ----------------------------------------------------------------------------
`default_nettype none
module eulr_cordic (
	input  wire logic                  clk,
	input  wire logic                  en,
	input  wire logic signed [15:0]    angle,
	output eulr_pkg::q20_t             sin_val,
	output eulr_pkg::q20_t             cos_val
);
	localparam int N = eulr_pkg::CORDIC_STAGES;

	eulr_pkg::q30_t x_q [N+1];
	eulr_pkg::q30_t y_q [N+1];
	eulr_pkg::q30_t z_q [N+1];
	logic           flip_q [N+1];
	eulr_pkg::q30_t z_w;
	eulr_pkg::q30_t xr, yr;

	// Widen to Q30 and fold into the right half plane.
	always_comb begin
		z_w = eulr_pkg::q30_t'(angle) <<< 17;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_q[0] <= eulr_pkg::GAIN_Q30;
			y_q[0] <= '0;
			if (z_w > eulr_pkg::ANG_HALF_PI) begin
				z_q[0] <= z_w - eulr_pkg::ANG_PI;
				flip_q[0] <= 1'b1;
			end else if (z_w < -eulr_pkg::ANG_HALF_PI) begin
				z_q[0] <= z_w + eulr_pkg::ANG_PI;
				flip_q[0] <= 1'b1;
			end else begin
				z_q[0] <= z_w;
				flip_q[0] <= 1'b0;
			end
		end
	end

	// One micro-rotation per register stage.
	for (genvar i = 0; i < N; i++) begin : g_stage
		localparam logic [4:0] K = 5'(i % 32);
		always_ff @(posedge clk) begin
			if (en) begin
				flip_q[i+1] <= flip_q[i];
				if (!z_q[i][33]) begin
					x_q[i+1] <= x_q[i] - (y_q[i] >>> K);
					y_q[i+1] <= y_q[i] + (x_q[i] >>> K);
					z_q[i+1] <= z_q[i] - eulr_pkg::atan_tab(K);
				end else begin
					x_q[i+1] <= x_q[i] + (y_q[i] >>> K);
					y_q[i+1] <= y_q[i] - (x_q[i] >>> K);
					z_q[i+1] <= z_q[i] + eulr_pkg::atan_tab(K);
				end
			end
		end
	end

	// Undo the fold and round to Q20.
	always_comb begin
		xr = flip_q[N] ? -x_q[N] : x_q[N];
		yr = flip_q[N] ? -y_q[N] : y_q[N];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sin_val <= eulr_pkg::q20_t'((yr + 34'sd512) >>> 10);
			cos_val <= eulr_pkg::q20_t'((xr + 34'sd512) >>> 10);
		end
	end
endmodule
`default_nettype wire

>>> design/euler_xyz_to_rotation_matrix_core.sv
// ----------------------------------------------------------------------------
// euler_xyz_to_rotation_matrix_core
// Rotation matrix from x-y-z Euler angles through CORDIC and multipliers.
// ----------------------------------------------------------------------------
// Usage: angle requests arrive on in_ch (psi, theta, phi in Q2.13) and the
// nine Q1.14 matrix entries leave on out_ch in row-major order, one result
// for each request. The block is one pipeline: a fold stage, CORDIC_STAGES
// rotation stages, a rounding stage, two multiplier stages and a sum and
// saturate stage. One request is taken in every cycle unless the receiver
// stalls. The whole pipeline advances together: when
// the receiver stalls with a result waiting, every stage holds and in_ch.ready
// falls, so nothing is lost or repeated; ready is high whenever the output
// stage is empty or being taken. Reset clears the valid bits only; the data
// registers carry no reset. The block keeps no state between requests.
// ----------------------------------------------------------------------------
`default_nettype none
module euler_xyz_to_rotation_matrix_core (
	input  wire logic     clk,
	input  wire logic     arst_n,
	eulr_angle_if.sink    in_ch,
	eulr_matrix_if.source out_ch
);
	localparam int LAT = eulr_pkg::CORDIC_STAGES + 5;

	logic           en;
	logic [LAT-1:0] vld_q;
	eulr_pkg::q20_t sx, cx, st, ct, sp, cp;

	assign en = !vld_q[LAT-1] || out_ch.ready;
	assign in_ch.ready = en;
	assign out_ch.valid = vld_q[LAT-1];

	// Valid bits travel with the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], in_ch.valid};
		end
	end

	eulr_cordic u_cx (.clk, .en, .angle(in_ch.data.angle_x), .sin_val(sx), .cos_val(cx));
	eulr_cordic u_cy (.clk, .en, .angle(in_ch.data.angle_y), .sin_val(st), .cos_val(ct));
	eulr_cordic u_cz (.clk, .en, .angle(in_ch.data.angle_z), .sin_val(sp), .cos_val(cp));

	// First products, Q40.
	typedef struct packed {
		logic signed [21:0] sx;
		logic signed [21:0] cx;
	} q20_hold_t;
	logic signed [43:0] ctcp_s1, ctsp_s1, stcp_s1, stsp_s1, ctsx_s1;
	logic signed [43:0] cxsp_s1, cxcp_s1, sxsp_s1, sxcp_s1, ctcx_s1;
	logic signed [43:0] st_s1;
	q20_hold_t hold_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			ctcp_s1 <= 44'(ct) * 44'(cp);
			ctsp_s1 <= 44'(ct) * 44'(sp);
			stcp_s1 <= 44'(st) * 44'(cp);
			stsp_s1 <= 44'(st) * 44'(sp);
			ctsx_s1 <= 44'(ct) * 44'(sx);
			cxsp_s1 <= 44'(cx) * 44'(sp);
			cxcp_s1 <= 44'(cx) * 44'(cp);
			sxsp_s1 <= 44'(sx) * 44'(sp);
			sxcp_s1 <= 44'(sx) * 44'(cp);
			ctcx_s1 <= 44'(ct) * 44'(cx);
			st_s1   <= 44'(st) <<< 20;
			hold_s1 <= {sx, cx};
		end
	end

	// Second products and scaled terms, Q60. The Q40 factor of each triple
	// product is split into a signed upper part and an unsigned lower 21 bits,
	// so every multiplier stays near 22 by 23 bits; the parts meet in the sum.
	typedef logic signed [67:0] q60_t;
	q60_t e00_s2, e01_s2, e02_s2, e12_s2, e22_s2;
	q60_t b10_s2, b11_s2, b20_s2, b21_s2;
	q60_t a10h_s2, a10l_s2, a11h_s2, a11l_s2, a20h_s2, a20l_s2, a21h_s2, a21l_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			e00_s2 <= q60_t'(ctcp_s1) <<< 20;
			e01_s2 <= -(q60_t'(ctsp_s1) <<< 20);
			e02_s2 <= q60_t'(st_s1) <<< 20;
			e12_s2 <= -(q60_t'(ctsx_s1) <<< 20);
			e22_s2 <= q60_t'(ctcx_s1) <<< 20;
			a10h_s2 <= q60_t'(hold_s1.sx) * q60_t'($signed(stcp_s1[43:21]));
			a10l_s2 <= q60_t'(hold_s1.sx) * q60_t'($signed({1'b0, stcp_s1[20:0]}));
			b10_s2 <= q60_t'(cxsp_s1) <<< 20;
			a11h_s2 <= q60_t'(hold_s1.sx) * q60_t'($signed(stsp_s1[43:21]));
			a11l_s2 <= q60_t'(hold_s1.sx) * q60_t'($signed({1'b0, stsp_s1[20:0]}));
			b11_s2 <= q60_t'(cxcp_s1) <<< 20;
			a20h_s2 <= q60_t'(hold_s1.cx) * q60_t'($signed(stcp_s1[43:21]));
			a20l_s2 <= q60_t'(hold_s1.cx) * q60_t'($signed({1'b0, stcp_s1[20:0]}));
			b20_s2 <= q60_t'(sxsp_s1) <<< 20;
			a21h_s2 <= q60_t'(hold_s1.cx) * q60_t'($signed(stsp_s1[43:21]));
			a21l_s2 <= q60_t'(hold_s1.cx) * q60_t'($signed({1'b0, stsp_s1[20:0]}));
			b21_s2 <= q60_t'(sxcp_s1) <<< 20;
		end
	end

	// Round a Q60 value to Q14 and saturate.
	function automatic logic signed [15:0] to_q14(input q60_t v);
		q60_t r;
		r = (v + (q60_t'(1) <<< 45)) >>> 46;
		if (r > q60_t'(eulr_pkg::SAT_MAX)) to_q14 = eulr_pkg::SAT_MAX;
		else if (r < -q60_t'(eulr_pkg::SAT_MAX)) to_q14 = -eulr_pkg::SAT_MAX;
		else to_q14 = r[15:0];
	endfunction

	// Sums, rounding and saturation into the output register.
	always_ff @(posedge clk) begin
		if (en) begin
			out_ch.data.m00 <= to_q14(e00_s2);
			out_ch.data.m01 <= to_q14(e01_s2);
			out_ch.data.m02 <= to_q14(e02_s2);
			out_ch.data.m10 <= to_q14((a10h_s2 <<< 21) + a10l_s2 + b10_s2);
			out_ch.data.m11 <= to_q14(b11_s2 - ((a11h_s2 <<< 21) + a11l_s2));
			out_ch.data.m12 <= to_q14(e12_s2);
			out_ch.data.m20 <= to_q14(b20_s2 - ((a20h_s2 <<< 21) + a20l_s2));
			out_ch.data.m21 <= to_q14((a21h_s2 <<< 21) + a21l_s2 + b21_s2);
			out_ch.data.m22 <= to_q14(e22_s2);
		end
	end
endmodule
`default_nettype wire

>>> tb/euler_xyz_to_rotation_matrix_core_tb.sv
// ----------------------------------------------------------------------------
// euler_xyz_to_rotation_matrix_core_tb
// Self-checking bench: angle requests with random gaps, results taken under
// random back-pressure and compared entry by entry with a local predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module euler_xyz_to_rotation_matrix_core_tb;
	localparam int PIPE_DEPTH  = eulr_pkg::CORDIC_STAGES + 5;
	localparam int CYCLE_LIMIT = 400000;
	localparam int N_RANDOM    = 1700;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	eulr_angle_if  angle_ch ();
	eulr_matrix_if matrix_ch ();

	euler_xyz_to_rotation_matrix_core DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (angle_ch.sink),
		.out_ch (matrix_ch.source)
	);

	eulr_pkg::angles_t pending_angles[$];
	eulr_pkg::matrix_t expected_matrices[$];
	int      send_gap = 0;
	int      stall_gap = 0;
	int      n_sent = 0;
	int      n_checked = 0;
	int      n_errors = 0;
	int      cycle_count = 0;
	bit      stimulus_done = 1'b0;

	// Clock generation.
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Arithmetic shift right on 64-bit values.
	function automatic longint asr(input longint v, input int s);
		asr = v >>> s;
	endfunction

	// Sine and cosine of a Q2.13 angle, both in Q20.
	task automatic angle_sincos(input logic signed [15:0] ang, output longint s20,
			output longint c20);
		longint z, x, y, nx, dx, dy;
		bit     flip;
		z = longint'(ang) * 131072;
		x = longint'(eulr_pkg::GAIN_Q30);
		y = 0;
		flip = 1'b0;
		if (z > longint'(eulr_pkg::ANG_HALF_PI)) begin
			z -= longint'(eulr_pkg::ANG_PI);
			flip = 1'b1;
		end else if (z < -longint'(eulr_pkg::ANG_HALF_PI)) begin
			z += longint'(eulr_pkg::ANG_PI);
			flip = 1'b1;
		end
		for (int i = 0; i < eulr_pkg::CORDIC_STAGES; i++) begin
			dx = asr(y, i % 32);
			dy = asr(x, i % 32);
			if (z >= 0) begin
				nx = x - dx;
				y = y + dy;
				z = z - longint'(eulr_pkg::atan_tab(5'(i)));
			end else begin
				nx = x + dx;
				y = y - dy;
				z = z + longint'(eulr_pkg::atan_tab(5'(i)));
			end
			x = nx;
		end
		if (flip) begin
			x = -x;
			y = -y;
		end
		s20 = asr(y + 512, 10);
		c20 = asr(x + 512, 10);
	endtask

	// Rounds a Q60 sum to Q1.14 and clamps it to plus or minus one.
	function automatic logic signed [15:0] round_q14(input longint v60);
		longint r;
		r = asr(v60 + (longint'(1) << 45), 46);
		if (r > 16384) r = 16384;
		if (r < -16384) r = -16384;
		round_q14 = 16'(r);
	endfunction

	// Predicted rotation matrix for one angle triple.
	task automatic predict_matrix(input eulr_pkg::angles_t a, output eulr_pkg::matrix_t m);
		longint sx, cx, st, ct, sp, cp;
		longint one;
		one = 1048576;
		angle_sincos(a.angle_x, sx, cx);
		angle_sincos(a.angle_y, st, ct);
		angle_sincos(a.angle_z, sp, cp);
		m.m00 = round_q14(ct * cp * one);
		m.m01 = round_q14(-ct * sp * one);
		m.m02 = round_q14(st * one * one);
		m.m10 = round_q14(sx * st * cp + cx * sp * one);
		m.m11 = round_q14(-sx * st * sp + cx * cp * one);
		m.m12 = round_q14(-ct * sx * one);
		m.m20 = round_q14(-cx * st * cp + sx * sp * one);
		m.m21 = round_q14(cx * st * sp + sx * cp * one);
		m.m22 = round_q14(ct * cx * one);
	endtask

	// Random angle: mostly uniform, sometimes near the fold points or ends.
	function automatic logic signed [15:0] rand_angle();
		case ($urandom_range(0, 9))
			0: rand_angle = 16'sd12868 + 16'($signed($urandom_range(0, 8)) - 4);
			1: rand_angle = -16'sd12868 + 16'($signed($urandom_range(0, 8)) - 4);
			2: rand_angle = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
			default: rand_angle = 16'($urandom);
		endcase
	endfunction

	// Stimulus: directed corners first, then random triples.
	initial begin
		logic signed [15:0] corners[12];
		eulr_pkg::angles_t a;
		corners = '{16'sh0000, 16'sh7fff, 16'sh8000, 16'sh0001, 16'shffff,
			16'sd12867, 16'sd12868, -16'sd12867, -16'sd12868,
			16'sd25736, -16'sd25736, 16'sh5555};
		foreach (corners[i]) begin
			a.angle_x = corners[i];
			a.angle_y = corners[(i + 3) % 12];
			a.angle_z = corners[(i + 7) % 12];
			pending_angles.push_back(a);
		end
		pending_angles.push_back('{16'sh7fff, 16'sh7fff, 16'sh7fff});
		pending_angles.push_back('{16'sh8000, 16'sh8000, 16'sh8000});
		pending_angles.push_back('{16'sh0000, 16'sh0000, 16'sh0000});
		pending_angles.push_back('{16'shaaaa, 16'sh5555, 16'shaaaa});
		for (int i = 0; i < N_RANDOM; i++) begin
			a.angle_x = rand_angle();
			a.angle_y = rand_angle();
			a.angle_z = rand_angle();
			pending_angles.push_back(a);
		end
		stimulus_done = 1'b1;
	end

	// Reset, held low and then released.
	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Request driver: one request per draw, with random gaps between requests.
	always @(posedge clk or negedge arst_n) begin
		eulr_pkg::matrix_t m;
		if (!arst_n) begin
			angle_ch.valid <= 1'b0;
			angle_ch.data <= '0;
			send_gap <= 0;
		end else if (angle_ch.valid && !angle_ch.ready) begin
			// Hold the request until it is taken.
		end else begin
			if (angle_ch.valid) begin
				predict_matrix(angle_ch.data, m);
				expected_matrices.push_back(m);
				n_sent <= n_sent + 1;
			end
			if (send_gap > 0) begin
				angle_ch.valid <= 1'b0;
				send_gap <= send_gap - 1;
			end else if (pending_angles.size() > 0) begin
				angle_ch.valid <= 1'b1;
				angle_ch.data <= pending_angles.pop_front();
				send_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
			end else begin
				angle_ch.valid <= 1'b0;
			end
		end
	end

	// Result monitor with random back-pressure.
	always @(posedge clk or negedge arst_n) begin
		eulr_pkg::matrix_t e, g;
		int errs;
		if (!arst_n) begin
			matrix_ch.ready <= 1'b0;
			stall_gap <= 0;
		end else begin
			errs = 0;
			if (matrix_ch.valid && matrix_ch.ready) begin
				g = matrix_ch.data;
				if (expected_matrices.size() == 0) begin
					$display("%0t: unexpected result %h", $time, g);
					errs = errs + 1;
				end else begin
					e = expected_matrices.pop_front();
					n_checked <= n_checked + 1;
					for (int k = 0; k < 9; k++) begin
						if (e[143 - 16*k -: 16] !== g[143 - 16*k -: 16]) begin
							$display("%0t: entry %0d%0d expected %0d got %0d", $time,
								k / 3, k % 3, $signed(e[143 - 16*k -: 16]),
								$signed(g[143 - 16*k -: 16]));
							errs = errs + 1;
						end
					end
				end
			end
			if (errs > 0) n_errors <= n_errors + errs;
			if (stall_gap > 0) begin
				matrix_ch.ready <= 1'b0;
				stall_gap <= stall_gap - 1;
			end else begin
				matrix_ch.ready <= 1'b1;
				if ($urandom_range(0, 2) == 0) stall_gap <= $urandom_range(0, 5);
			end
		end
	end

	// Watchdog on the total run length.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timed out after %0d cycles", cycle_count);
			$display("FAILURE");
			$finish;
		end
	end

	// End of run: all requests taken, all results checked, then a drain.
	initial begin
		wait (stimulus_done && arst_n);
		wait (pending_angles.size() == 0 && !angle_ch.valid);
		wait (expected_matrices.size() == 0);
		repeat (PIPE_DEPTH + 10) @(posedge clk);
		$display("Sent %0d angle requests, checked %0d matrices with random gaps and stalls.",
			n_sent, n_checked);
		if (n_errors == 0 && expected_matrices.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end
endmodule
`default_nettype wire
